### src/scanline_run_extractor_macros.svh
// Assertion macros used by the checker file of the run extractor.
`ifndef SCANLINE_RUN_EXTRACTOR_MACROS_SVH
`define SCANLINE_RUN_EXTRACTOR_MACROS_SVH

// Checked on every clock edge outside of reset.
`define SRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sre_pkg.sv
`default_nettype none
package sre_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 4096;
  localparam int MAX_ROWS_DEF      = 4096;

  localparam int CFG_W   = 13;
  localparam int THR_W   = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 12;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  localparam logic [THR_W-1:0] GRAY_THRESHOLD_RST = 8'd192;
  localparam logic [CFG_W-1:0] MIN_RUN_LENGTH_RST = 13'd8;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST      = 13'd4096;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST      = 13'd4096;

  typedef enum logic [1:0] {
    REG_GRAY_THRESHOLD = 2'd0,
    REG_MIN_RUN_LENGTH = 2'd1,
    REG_ROW_WIDTH      = 2'd2,
    REG_ROW_COUNT      = 2'd3
  } cfg_idx_t;

  // First member lands in the top bits, so the row sits lowest.
  typedef struct packed {
    logic [LEN_W-1:0]   run_length;
    logic [START_W-1:0] run_start;
    logic [ROW_W-1:0]   run_row;
  } run_t;

  // Weighted luma: (11*r + 16*g + 5*b) / 32; the sum fits in 13 bits.
  function automatic logic [COLOR_W-1:0] gray_of(input logic [COLOR_W-1:0] r,
                                                 input logic [COLOR_W-1:0] g,
                                                 input logic [COLOR_W-1:0] b);
    logic [12:0] sum;
    sum = 13'(r) * 13'd11 + 13'(g) * 13'd16 + 13'(b) * 13'd5;
    return sum[12:5];
  endfunction

endpackage
`default_nettype wire

### src/sre_luma.sv
`default_nettype none
module sre_luma (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic                             drain,
  input  wire logic [sre_pkg::COLOR_W-1:0]      red,
  input  wire logic [sre_pkg::COLOR_W-1:0]      green,
  input  wire logic [sre_pkg::COLOR_W-1:0]      blue,
  input  wire logic [sre_pkg::THR_W-1:0]        gray_threshold,
  output logic                                  pix_valid,
  output logic                                  light
);

  logic [sre_pkg::COLOR_W-1:0] red_q;
  logic [sre_pkg::COLOR_W-1:0] green_q;
  logic [sre_pkg::COLOR_W-1:0] blue_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (load) begin
      pix_valid <= 1'b1;
    end else if (drain) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
    end
  end

  assign light = sre_pkg::gray_of(red_q, green_q, blue_q) > gray_threshold;

endmodule
`default_nettype wire

### src/sre_run_tracker.sv
`default_nettype none
module sre_run_tracker #(
  parameter int MAX_ROW_WIDTH = sre_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MAX_ROWS      = sre_pkg::MAX_ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         light,
  input  wire logic [sre_pkg::CFG_W-1:0]    min_run_length,
  input  wire logic [sre_pkg::CFG_W-1:0]    row_width,
  input  wire logic [sre_pkg::CFG_W-1:0]    row_count,
  output logic                              emit,
  output sre_pkg::run_t                     run
);

  localparam int CW  = $clog2(MAX_ROW_WIDTH);
  localparam int XW  = CW + 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RXW = RW + 1;

  logic [CW-1:0] column_index;
  logic [RW-1:0] row_index;
  logic          in_light_run;
  logic [CW-1:0] light_run_start;

  logic [CW-1:0] column_index_next;
  logic [RW-1:0] row_index_next;
  logic          in_light_run_next;
  logic [CW-1:0] light_run_start_next;

  logic [XW-1:0]  width_eff;
  logic [31:0]    rows_eff;
  logic [XW-1:0]  col_inc;
  logic [RXW-1:0] row_inc;
  logic [XW-1:0]  len;
  logic [CW-1:0]  start_sel;

  // Out-of-range widths and counts are pulled into their legal ranges.
  always_comb begin
    if (row_width == '0) begin
      width_eff = XW'(1);
    end else if (32'(row_width) > 32'(MAX_ROW_WIDTH)) begin
      width_eff = XW'(MAX_ROW_WIDTH);
    end else begin
      width_eff = XW'(row_width);
    end
    if (row_count == '0) begin
      rows_eff = 32'd1;
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end else begin
      rows_eff = 32'(row_count);
    end
  end

  always_comb begin
    column_index_next    = column_index;
    row_index_next       = row_index;
    in_light_run_next    = in_light_run;
    light_run_start_next = light_run_start;
    len                  = '0;
    emit                 = 1'b0;
    start_sel            = light_run_start;
    col_inc              = {1'b0, column_index} + XW'(1);
    row_inc              = {1'b0, row_index} + RXW'(1);

    if (in_light_run) begin
      if (!light) begin
        in_light_run_next = 1'b0;
        len  = {1'b0, column_index} - {1'b0, light_run_start};
        emit = 32'(len) >= 32'(min_run_length);
      end
    end else if (light) begin
      in_light_run_next    = 1'b1;
      light_run_start_next = column_index;
    end

    if (col_inc >= width_eff) begin
      // The row closes here; a run still open ends with the row. A run that
      // opens on this very pixel starts at the current column.
      if (in_light_run_next) begin
        len       = col_inc - {1'b0, light_run_start_next};
        emit      = 32'(len) >= 32'(min_run_length);
        start_sel = light_run_start_next;
      end
      in_light_run_next    = 1'b0;
      light_run_start_next = '0;
      column_index_next    = '0;
      row_index_next       = (32'(row_inc) >= rows_eff) ? '0 : RW'(row_inc);
    end else begin
      column_index_next = CW'(col_inc);
    end
  end

  always_comb begin
    run.run_row    = sre_pkg::ROW_W'(row_index);
    run.run_start  = sre_pkg::START_W'(start_sel);
    run.run_length = sre_pkg::LEN_W'(len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index    <= '0;
      row_index       <= '0;
      in_light_run    <= 1'b0;
      light_run_start <= '0;
    end else if (step) begin
      column_index    <= column_index_next;
      row_index       <= row_index_next;
      in_light_run    <= in_light_run_next;
      light_run_start <= light_run_start_next;
    end
  end

endmodule
`default_nettype wire

### src/sre_out_buf.sv
`default_nettype none
module sre_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sre_pkg::run_t din,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sre_pkg::run_t      dout
);

  sre_pkg::run_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign dout      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### src/scanline_run_extractor.sv
// A result beat is offered once the pixel register has stepped the pixel beat closing
// its run into the result buffer; a full result buffer can hold that step back.
// Throughput: one pixel per clock, sustained while the result side keeps up.
// The two-entry result buffer absorbs up to two runs while the result side stalls.
// Reset (rst, synchronous, active high) clears the column and row counters, the open
// run and the result buffer, and loads the default register values.
`default_nettype none
module scanline_run_extractor #(
  parameter int MAX_ROW_WIDTH = sre_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MAX_ROWS      = sre_pkg::MAX_ROWS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Pixel stream.
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [23:0]                s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // Run stream.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [39:0]                     m_tdata,   // run_row[11:0], run_start[23:12],
                                                     // run_length[36:24], zero[39:37]
  // Register writes.
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [sre_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers. Writes must land only while the block is idle; the block itself does not enforce this.
  logic [sre_pkg::THR_W-1:0] gray_threshold;
  logic [sre_pkg::CFG_W-1:0] min_run_length;
  logic [sre_pkg::CFG_W-1:0] row_width;
  logic [sre_pkg::CFG_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= sre_pkg::GRAY_THRESHOLD_RST;
      min_run_length <= sre_pkg::MIN_RUN_LENGTH_RST;
      row_width      <= sre_pkg::ROW_WIDTH_RST;
      row_count      <= sre_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (sre_pkg::cfg_idx_t'(cfg_index))
        sre_pkg::REG_GRAY_THRESHOLD: gray_threshold <= cfg_data[sre_pkg::THR_W-1:0];
        sre_pkg::REG_MIN_RUN_LENGTH: min_run_length <= cfg_data;
        sre_pkg::REG_ROW_WIDTH:      row_width      <= cfg_data;
        sre_pkg::REG_ROW_COUNT:      row_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pixel register holds one beat. It is processed on the edge at which the
  // result buffer has room, or at once when the pixel closes no reported run.
  // The ready decision looks only at registered state, so the result side's
  // ready never reaches the pixel side's ready.
  logic          pix_valid;
  logic          light;
  logic          emit;
  logic          buf_full;
  logic          step;
  logic          accept;
  sre_pkg::run_t run;
  sre_pkg::run_t run_out;

  assign step     = pix_valid && (!emit || !buf_full);
  assign s_tready = !pix_valid || step;
  assign accept   = s_tvalid && s_tready;

  sre_luma u_luma (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .drain          (step),
    .red            (s_tdata[7:0]),
    .green          (s_tdata[15:8]),
    .blue           (s_tdata[23:16]),
    .gray_threshold (gray_threshold),
    .pix_valid      (pix_valid),
    .light          (light)
  );

  // Column and row counters and the open run; decides whether a run closes.
  sre_run_tracker #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .MAX_ROWS      (MAX_ROWS)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .light          (light),
    .min_run_length (min_run_length),
    .row_width      (row_width),
    .row_count      (row_count),
    .emit           (emit),
    .run            (run)
  );

  // Results wait here until the downstream side takes them.
  sre_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step && emit),
    .din       (run),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (run_out)
  );

  assign m_tdata = {3'b000, run_out};

endmodule
`default_nettype wire

### src/sre_checker.sv
`default_nettype none
`include "scanline_run_extractor_macros.svh"
module sre_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // The result buffer is empty right after reset.
  `SRE_ASSERT_ALWAYS(a_empty_after_rst, rst |=> !m_tvalid, "result offered after reset")

  // A stalled result beat keeps its payload.
  `SRE_ASSERT(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
              "stalled result beat changed")

  // Every reported run covers at least one pixel, and the pad bits stay zero.
  `SRE_ASSERT(a_len_nonzero, m_tvalid |-> (m_tdata[36:24] != 13'd0) && (m_tdata[39:37] == 3'd0),
              "bad run length or pad bits")

  // A fresh result needs an accepted pixel beat before it.
  `SRE_ASSERT(a_cause, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) ||
              $past(m_tvalid, 2), "result without a pixel beat")

endmodule

bind scanline_run_extractor sre_checker u_sre_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/scanline_run_extractor_checker.sv
module scanline_run_extractor_checker
  import sre_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [23:0]       s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [39:0]       m_tdata,   // run_row[11:0], run_start[23:12],
                                            // run_length[36:24], zero[39:37]
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output int                     failures,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the register file.
  logic [THR_W-1:0] thr_q;
  logic [CFG_W-1:0] min_len_q;
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] rows_q;

  // Scan position and the open light run.
  logic [ROW_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic               run_open_q;
  logic [START_W-1:0] run_start_q;

  run_t expected_runs[$];

  task automatic log_run(input int unsigned start, input int unsigned len);
    run_t r;
    if (len >= min_len_q) begin
      r.run_row    = row_q;
      r.run_start  = start[START_W-1:0];
      r.run_length = len[LEN_W-1:0];
      expected_runs.push_back(r);
    end
  endtask

  task automatic track_runs(input logic [23:0] pix);
    int unsigned gray;
    int unsigned width;
    int unsigned rows;
    int unsigned x;
    int unsigned next_row;
    bit          light;
    gray  = (11 * int'(pix[7:0]) + 16 * int'(pix[15:8]) + 5 * int'(pix[23:16])) >> 5;
    light = gray > thr_q;
    width = (width_q == 0) ? 1 : ((width_q > MAX_ROW_WIDTH_DEF) ? MAX_ROW_WIDTH_DEF : width_q);
    rows  = (rows_q == 0) ? 1 : ((rows_q > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_q);
    x     = col_q;

    if (run_open_q) begin
      if (!light) begin
        run_open_q = 1'b0;
        log_run(run_start_q, x - run_start_q);
      end
    end else if (light) begin
      run_open_q  = 1'b1;
      run_start_q = x[START_W-1:0];
    end

    x++;
    if (x >= width) begin
      // The row closes here; a run still open ends with it.
      if (run_open_q && x > run_start_q) log_run(run_start_q, x - run_start_q);
      run_open_q  = 1'b0;
      run_start_q = '0;
      col_q       = '0;
      next_row    = row_q + 1;
      if (next_row >= rows) next_row = 0;
      row_q = next_row[ROW_W-1:0];
    end else begin
      col_q = x[ROW_W-1:0];
    end
  endtask

  task automatic check_run(input logic [39:0] beat);
    run_t got;
    run_t want;
    got = beat[36:0];
    if (expected_runs.size() == 0) begin
      $error("run beat with none expected: row %0d start %0d length %0d",
             got.run_row, got.run_start, got.run_length);
      failures++;
    end else begin
      want = expected_runs.pop_front();
      if (got.run_row !== want.run_row) begin
        $error("run_row: expected %0d, got %0d", want.run_row, got.run_row);
        failures++;
      end
      if (got.run_start !== want.run_start) begin
        $error("run_start: expected %0d, got %0d", want.run_start, got.run_start);
        failures++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
        failures++;
      end
      if (beat[39:37] !== 3'b000) begin
        $error("zero padding: expected 0, got %0d", beat[39:37]);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_q       = GRAY_THRESHOLD_RST;
      min_len_q   = MIN_RUN_LENGTH_RST;
      width_q     = ROW_WIDTH_RST;
      rows_q      = ROW_COUNT_RST;
      col_q       = '0;
      row_q       = '0;
      run_open_q  = 1'b0;
      run_start_q = '0;
      expected_runs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRAY_THRESHOLD: thr_q     = cfg_data[THR_W-1:0];
          REG_MIN_RUN_LENGTH: min_len_q = cfg_data;
          REG_ROW_WIDTH:      width_q   = cfg_data;
          REG_ROW_COUNT:      rows_q    = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) track_runs(s_tdata);
      if (m_tvalid && m_tready) check_run(m_tdata);
    end
    pending <= expected_runs.size();
  end

endmodule

### tb/scanline_run_extractor_tb.sv
module scanline_run_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  // Watchdog limit: several times what the slowest correct run needs, with
  // room for the settle waits between settings.
  localparam int CYCLE_LIMIT  = 400000;
  // A run beat is offered once the pixel closing it has passed the pixel
  // register into the result buffer. Before a register write, pixels that
  // close nothing are given a settle wait too.
  localparam int DRAIN_CYCLES = 8;

  // Pixel values are packed as {blue, green, red}.
  localparam logic [23:0] WHITE      = 24'hFFFFFF;
  localparam logic [23:0] BLACK      = 24'h000000;
  localparam logic [23:0] RED_FULL   = 24'h0000FF;  // gray 87
  localparam logic [23:0] GREEN_FULL = 24'h00FF00;  // gray 127
  localparam logic [23:0] BLUE_FULL  = 24'hFF0000;  // gray 39
  localparam logic [23:0] GREEN_200  = 24'h00C800;  // gray 100
  localparam logic [23:0] GREEN_202  = 24'h00CA00;  // gray 101
  localparam logic [23:0] GRAY_ONE   = 24'h010101;  // gray 1

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic [23:0]      s_tdata   = '0;
  logic             m_tready  = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [39:0] m_tdata;

  int failures;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  scanline_run_extractor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scanline_run_extractor_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run side stalls at random; the share of stalled cycles is set per phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a lost run beat ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Writes all four registers on consecutive edges. Only called while the
  // block is idle, so no pixel shares an edge with a register write.
  task automatic apply_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] min_len,
                                input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRAY_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_MIN_RUN_LENGTH;
    cfg_data  <= min_len;
    @(posedge clk);
    cfg_index <= REG_ROW_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offers one pixel beat, after a random number of idle cycles, and returns
  // on the edge that accepts it. tvalid stays high so back-to-back beats work.
  task automatic send_pixel(input logic [23:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the pixel side off until every predicted run has come out, then
  // lets the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random color on the requested side of the threshold. When no random try
  // lands there (nothing is light above 255, for one) a fixed color is used.
  function automatic logic [23:0] pick_color(input bit want_light, input logic [7:0] thr);
    logic [23:0] c;
    int unsigned gray;
    for (int i = 0; i < 64; i++) begin
      c    = 24'($urandom);
      gray = (11 * int'(c[7:0]) + 16 * int'(c[15:8]) + 5 * int'(c[23:16])) >> 5;
      if ((gray > thr) == want_light) return c;
    end
    return want_light ? WHITE : BLACK;
  endfunction

  // One random setting followed by a burst of pixels. Most pixels follow
  // light and dark stretches so that runs of every length form; some are
  // plain noise. Widths are mostly small so that rows close often.
  task automatic run_segment(input int n_pixels);
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] rows;
    int unsigned      pick;
    bit               lit;
    logic [23:0]      pix;

    pick = $urandom_range(99);
    if (pick < 80)      width = CFG_W'($urandom_range(24, 2));
    else if (pick < 90) width = CFG_W'($urandom_range(200, 25));
    else if (pick < 93) width = CFG_W'(4096);
    else if (pick < 96) width = CFG_W'($urandom_range(1, 0));
    else                width = CFG_W'($urandom_range(8191, 4097));

    pick = $urandom_range(99);
    if (pick < 70)      min_len = CFG_W'($urandom_range(3, 0));
    else if (pick < 90) min_len = CFG_W'($urandom_range(int'(width) + 1, 4));
    else                min_len = CFG_W'($urandom_range(8191, 0));

    pick = $urandom_range(99);
    if (pick < 70)      rows = CFG_W'($urandom_range(4, 1));
    else if (pick < 80) rows = '0;
    else if (pick < 90) rows = ($urandom_range(1) != 0) ? CFG_W'(4096) : CFG_W'(8191);
    else                rows = CFG_W'($urandom_range(8191, 0));

    pick = $urandom_range(99);
    if (pick < 85)      thr = CFG_W'($urandom_range(220, 40));
    else if (pick < 95) thr = '0;
    else                thr = CFG_W'(255);

    drain();
    apply_settings(thr, min_len, width, rows);
    lit = ($urandom_range(1) != 0);
    repeat (n_pixels) begin
      if ($urandom_range(99) < 25) lit = !lit;
      if ($urandom_range(99) < 15) pix = 24'($urandom);
      else                         pix = pick_color(lit, thr[7:0]);
      send_pixel(pix);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Six-pixel rows, two rows per frame, every run reported. The first row
    // has a run ended by a dark pixel, a longer one, and a light pixel in the
    // last column that closes at the row end.
    apply_settings(CFG_W'(100), CFG_W'(0), CFG_W'(6), CFG_W'(2));
    send_pixel(WHITE);
    send_pixel(BLACK);
    send_pixel(WHITE);
    send_pixel(WHITE);
    send_pixel(BLACK);
    send_pixel(WHITE);
    // Second row: each color channel at full scale alone, gray exactly at the
    // threshold (dark) and one above it (light), then a dark pixel in the
    // last column that ends the open run by itself. The frame then wraps.
    send_pixel(GREEN_FULL);
    send_pixel(BLUE_FULL);
    send_pixel(RED_FULL);
    send_pixel(GREEN_200);
    send_pixel(GREEN_202);
    send_pixel(BLACK);

    // Highest threshold: no pixel can be light. Row width and row count
    // above their maximum are clamped.
    drain();
    apply_settings(CFG_W'(255), CFG_W'(0), CFG_W'(8191), CFG_W'(8191));
    send_pixel(WHITE);
    send_pixel(BLACK);
    send_pixel(WHITE);

    // Zero threshold, zero row width and row count (both taken as one), and
    // a minimum above any row width, so nothing is reported.
    drain();
    apply_settings(CFG_W'(0), CFG_W'(8191), CFG_W'(0), CFG_W'(0));
    send_pixel(WHITE);
    send_pixel(GRAY_ONE);
    send_pixel(BLACK);

    // Open a run in a wide row, then shrink the row under it: the next pixel
    // is past the new width and closes both the row and the run.
    drain();
    apply_settings(CFG_W'(0), CFG_W'(1), CFG_W'(8), CFG_W'(3));
    repeat (5) send_pixel(WHITE);
    drain();
    apply_settings(CFG_W'(0), CFG_W'(1), CFG_W'(3), CFG_W'(3));
    send_pixel(WHITE);

    // Random part in three phases: a slow result side, a slow pixel side,
    // and both at full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 22;
          recv_idle_pct <= 86;
        end
        1: begin
          send_idle_pct <= 86;
          recv_idle_pct <= 22;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      repeat (10) run_segment($urandom_range(70, 35));
    end

    drain();
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/sre_pkg.sv
src/sre_luma.sv
src/sre_run_tracker.sv
src/sre_out_buf.sv
src/scanline_run_extractor.sv
src/sre_checker.sv
tb/scanline_run_extractor_checker.sv
tb/scanline_run_extractor_tb.sv
